// ===== src/ajrb_pkg.sv =====
package ajrb_pkg;

   localparam int RING_DEPTH_DEFAULT   = 32768;
   localparam int MAX_CHANNELS_DEFAULT = 8;

   localparam int FRAME_BITS  = 128;
   localparam int PAIR_COUNT  = 4;
   localparam int LANE_COUNT  = 8;
   localparam int COUNT_BITS  = 32;

   // register reset values
   localparam logic [3:0]  CHANNELS_RESET = 4'd2;
   localparam logic [15:0] TARGET_RESET   = 16'd1;
   localparam int          CAPACITY_RESET = 32768;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_ARM   = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_DROP_FULL   = 3'd1,
      ST_REFUSED     = 3'd2,
      ST_UNDERRUN    = 3'd3,
      ST_STOPPED     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_CHANNELS = 2'd0,
      CSR_TARGET   = 2'd1,
      CSR_CAPACITY = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

endpackage

// ===== src/audio_jitter_ring_buffer.sv =====
// channel    ports                              direction   handshake
// request    req_command .. req_in_pair_3       in          req_valid / req_stall
// response   rsp_out_pair_0 .. rsp_dropped_..   out         rsp_valid / rsp_stall
// csr        csr_index, csr_wdata               in          csr_valid / csr_ready
//
// A response is valid once it has passed the middle stage and the response register:
// the ring state updates at the transfer and the frame store is read in the same
// cycle, its registered read data arriving together with the middle stage.
// One item per cycle is sustained while responses are taken; the one-port-each frame
// store sets that.
// Synchronous reset clears pointers, flags and counters; the frame store is not
// cleared. A stalled response holds the middle stage, which then stalls requests.
module audio_jitter_ring_buffer
   import ajrb_pkg::*;
#(
   parameter int RING_DEPTH   = RING_DEPTH_DEFAULT,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_callback_start,
   input  logic [31:0] req_in_pair_0,
   input  logic [31:0] req_in_pair_1,
   input  logic [31:0] req_in_pair_2,
   input  logic [31:0] req_in_pair_3,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_pair_0,
   output logic [31:0] rsp_out_pair_1,
   output logic [31:0] rsp_out_pair_2,
   output logic [31:0] rsp_out_pair_3,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_queued_frames,
   output logic        rsp_playing,
   output logic [31:0] rsp_underrun_callback_count,
   output logic [31:0] rsp_underrun_frame_count,
   output logic [31:0] rsp_dropped_frame_count,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int PW   = $clog2(RING_DEPTH);
   localparam int CW   = $clog2(RING_DEPTH + 1);
   localparam int CMPW = (CW > 16) ? CW : 16;
   localparam int CAP_RESET_VAL = (CAPACITY_RESET < RING_DEPTH) ? CAPACITY_RESET : RING_DEPTH;

   // configuration
   logic [3:0]    chan_ff;
   logic [15:0]   target_ff;
   logic [CW-1:0] cap_ff;
   logic [CW-1:0] cap_in;

   // ring state
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          armed_ff, armed_in;
   logic          started_ff, started_in;
   logic          closing_ff, closing_in;
   logic          short_ff, short_in;
   logic [COUNT_BITS-1:0] ucb_ff, ucb_in;
   logic [COUNT_BITS-1:0] ufr_ff, ufr_in;
   logic [COUNT_BITS-1:0] drop_ff, drop_in;

   // middle stage
   logic                  s1_valid_ff;
   logic                  s1_read_ok_ff;
   logic [LANE_COUNT-1:0] s1_lane_en_ff;
   status_type            s1_status_ff;
   logic [15:0]           s1_queued_ff;
   logic                  s1_playing_ff;
   logic [COUNT_BITS-1:0] s1_ucb_ff, s1_ufr_ff, s1_drop_ff;

   // response register
   logic                  rsp_valid_ff;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;
   status_type            rsp_status_ff;
   logic [15:0]           rsp_queued_ff;
   logic                  rsp_playing_ff;
   logic [COUNT_BITS-1:0] rsp_ucb_ff, rsp_ufr_ff, rsp_drop_ff;

   logic                  accept;
   logic                  advance;
   logic                  csr_write;
   logic                  cap_flush;
   status_type            status_in;
   logic                  read_ok_in;
   logic                  mem_wr_en, mem_rd_en;
   logic [FRAME_BITS-1:0] mem_rd_data;
   logic [3:0]            chan_eff;
   logic [LANE_COUNT-1:0] lane_en;
   logic [CW-1:0]         wp_inc, rp_inc;
   logic [CMPW-1:0]       cap_wdata;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cap_flush = csr_write && (csr_index_type'(csr_index) == CSR_CAPACITY);

   // clamp the channel count to 1..MAX_CHANNELS for lane masking
   always_comb begin
      chan_eff = chan_ff;
      if (chan_eff == 4'd0) begin
         chan_eff = 4'd1;
      end else if (chan_eff > 4'(MAX_CHANNELS)) begin
         chan_eff = 4'(MAX_CHANNELS);
      end
      for (int l = 0; l < LANE_COUNT; l++) begin
         lane_en[l] = 4'(l) < chan_eff;
      end
   end

   // clamp the capacity write to 1..RING_DEPTH
   always_comb begin
      cap_wdata = CMPW'(csr_wdata);
      if (cap_wdata == '0) begin
         cap_in = CW'(1);
      end else if (cap_wdata > CMPW'(RING_DEPTH)) begin
         cap_in = CW'(RING_DEPTH);
      end else begin
         cap_in = CW'(cap_wdata);
      end
   end

   assign wp_inc = CW'(wp_ff) + CW'(1);
   assign rp_inc = CW'(rp_ff) + CW'(1);

   always_comb begin
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      armed_in   = armed_ff;
      started_in = started_ff;
      closing_in = closing_ff;
      short_in   = short_ff;
      ucb_in     = ucb_ff;
      ufr_in     = ufr_ff;
      drop_in    = drop_ff;
      status_in  = ST_OK;
      read_ok_in = 1'b0;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      if (accept) begin
         unique case (cmd_type'(req_command))
            CMD_WRITE: begin
               if (closing_ff) begin
                  status_in = ST_REFUSED;
               end else begin
                  if (fill_ff >= cap_ff) begin
                     status_in = ST_DROP_FULL;
                     drop_in   = drop_ff + COUNT_BITS'(1);
                  end else begin
                     mem_wr_en = 1'b1;
                     wp_in     = (wp_inc >= cap_ff) ? '0 : wp_inc[PW-1:0];
                     fill_in   = fill_ff + CW'(1);
                  end
                  if (armed_ff && CMPW'(fill_in) >= CMPW'(target_ff)) begin
                     started_in = 1'b1;
                  end
               end
            end
            CMD_READ: begin
               if (closing_ff) begin
                  status_in = ST_STOPPED;
               end else begin
                  short_in = req_callback_start ? 1'b0 : short_ff;
                  if (fill_ff == '0) begin
                     status_in = ST_UNDERRUN;
                     ufr_in    = ufr_ff + COUNT_BITS'(1);
                     if (!short_in) begin
                        ucb_in   = ucb_ff + COUNT_BITS'(1);
                        short_in = 1'b1;
                     end
                  end else begin
                     mem_rd_en  = 1'b1;
                     read_ok_in = 1'b1;
                     rp_in      = (rp_inc >= cap_ff) ? '0 : rp_inc[PW-1:0];
                     fill_in    = fill_ff - CW'(1);
                  end
               end
            end
            CMD_ARM: begin
               armed_in = 1'b1;
               if (!closing_ff && CMPW'(fill_ff) >= CMPW'(target_ff)) begin
                  started_in = 1'b1;
               end
            end
            CMD_CLOSE: begin
               closing_in = 1'b1;
               armed_in   = 1'b0;
               started_in = 1'b0;
            end
         endcase
      end
   end

   ajrb_ram #(
      .WIDTH (FRAME_BITS),
      .DEPTH (RING_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wp_ff),
      .wr_data ({req_in_pair_3, req_in_pair_2, req_in_pair_1, req_in_pair_0}),
      .rd_en   (mem_rd_en),
      .rd_addr (rp_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff    <= CHANNELS_RESET;
         target_ff  <= TARGET_RESET;
         cap_ff     <= CW'(CAP_RESET_VAL);
         rp_ff      <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         armed_ff   <= 1'b0;
         started_ff <= 1'b0;
         closing_ff <= 1'b0;
         short_ff   <= 1'b0;
         ucb_ff     <= '0;
         ufr_ff     <= '0;
         drop_ff    <= '0;
      end else begin
         armed_ff   <= armed_in;
         started_ff <= started_in;
         closing_ff <= closing_in;
         short_ff   <= short_in;
         ucb_ff     <= ucb_in;
         ufr_ff     <= ufr_in;
         drop_ff    <= drop_in;
         if (cap_flush) begin
            // new capacity flushes the ring
            rp_ff   <= '0;
            wp_ff   <= '0;
            fill_ff <= '0;
         end else begin
            rp_ff   <= rp_in;
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_CHANNELS: chan_ff <= csr_wdata[3:0];
               CSR_TARGET:   target_ff <= csr_wdata;
               CSR_CAPACITY: cap_ff <= cap_in;
               CSR_UNUSED: ;
            endcase
         end
      end
   end

   // middle stage waits for the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ok_ff <= read_ok_in;
         s1_lane_en_ff <= lane_en;
         s1_status_ff  <= status_in;
         s1_queued_ff  <= 16'(fill_in);
         s1_playing_ff <= started_in;
         s1_ucb_ff     <= ucb_in;
         s1_ufr_ff     <= ufr_in;
         s1_drop_ff    <= drop_in;
      end
   end

   always_comb begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
         rsp_frame_in[32*p +: 32] = s1_read_ok_ff ?
            (mem_rd_data[32*p +: 32] & {{16{s1_lane_en_ff[2*p+1]}},
                                        {16{s1_lane_en_ff[2*p]}}}) : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_frame_ff   <= rsp_frame_in;
         rsp_status_ff  <= s1_status_ff;
         rsp_queued_ff  <= s1_queued_ff;
         rsp_playing_ff <= s1_playing_ff;
         rsp_ucb_ff     <= s1_ucb_ff;
         rsp_ufr_ff     <= s1_ufr_ff;
         rsp_drop_ff    <= s1_drop_ff;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_out_pair_0              = rsp_frame_ff[31:0];
   assign rsp_out_pair_1              = rsp_frame_ff[63:32];
   assign rsp_out_pair_2              = rsp_frame_ff[95:64];
   assign rsp_out_pair_3              = rsp_frame_ff[127:96];
   assign rsp_status                  = rsp_status_ff;
   assign rsp_queued_frames           = rsp_queued_ff;
   assign rsp_playing                 = rsp_playing_ff;
   assign rsp_underrun_callback_count = rsp_ucb_ff;
   assign rsp_underrun_frame_count    = rsp_ufr_ff;
   assign rsp_dropped_frame_count     = rsp_drop_ff;

endmodule

// ===== src/ajrb_ram.sv =====
module ajrb_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb
   import ajrb_pkg::*;
();

   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENTS       = 8;
   localparam int SEGMENT_ITEMS  = 115;

   typedef enum {STEP_ITEM, STEP_REG, STEP_DRAIN, STEP_MODE} step_kind_type;

   typedef struct {
      step_kind_type kind;
      cmd_type       cmd;
      logic          cb;
      logic [127:0]  data;
      csr_index_type idx;
      logic [15:0]   wdata;
      int            idle_pct;
      int            stall_pct;
   } cmd_step_type;

   typedef struct packed {
      logic [127:0] frame;
      status_type   status;
      logic [15:0]  queued;
      logic         playing;
      logic [31:0]  ucb;
      logic [31:0]  ufr;
      logic [31:0]  drop;
   } ring_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic        req_callback_start;
   logic [31:0] req_in_pair_0;
   logic [31:0] req_in_pair_1;
   logic [31:0] req_in_pair_2;
   logic [31:0] req_in_pair_3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_pair_0;
   logic [31:0] rsp_out_pair_1;
   logic [31:0] rsp_out_pair_2;
   logic [31:0] rsp_out_pair_3;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_queued_frames;
   logic        rsp_playing;
   logic [31:0] rsp_underrun_callback_count;
   logic [31:0] rsp_underrun_frame_count;
   logic [31:0] rsp_dropped_frame_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   audio_jitter_ring_buffer DUT (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_command                 (req_command),
      .req_callback_start          (req_callback_start),
      .req_in_pair_0               (req_in_pair_0),
      .req_in_pair_1               (req_in_pair_1),
      .req_in_pair_2               (req_in_pair_2),
      .req_in_pair_3               (req_in_pair_3),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_out_pair_0              (rsp_out_pair_0),
      .rsp_out_pair_1              (rsp_out_pair_1),
      .rsp_out_pair_2              (rsp_out_pair_2),
      .rsp_out_pair_3              (rsp_out_pair_3),
      .rsp_status                  (rsp_status),
      .rsp_queued_frames           (rsp_queued_frames),
      .rsp_playing                 (rsp_playing),
      .rsp_underrun_callback_count (rsp_underrun_callback_count),
      .rsp_underrun_frame_count    (rsp_underrun_frame_count),
      .rsp_dropped_frame_count     (rsp_dropped_frame_count),
      .csr_valid                   (csr_valid),
      .csr_ready                   (csr_ready),
      .csr_index                   (csr_index),
      .csr_wdata                   (csr_wdata)
   );

   always #2 clock = ~clock;

   // jitter buffer shadow state
   logic [127:0] ring_model [0:RING_DEPTH_DEFAULT-1];
   int unsigned  m_rd, m_wr, m_fill;
   logic         m_armed, m_started, m_closing, m_cb_short;
   logic [31:0]  m_ucb, m_ufr, m_drop;
   logic [3:0]   m_channels;
   logic [15:0]  m_target, m_capacity;

   ring_rsp_type  ring_replies [$];
   cmd_step_type  cmd_backlog [$];

   int   mismatches;
   int   send_idle_pct, rsp_stall_pct;
   logic draining;
   int   settle_left;
   logic req_taken, csr_taken;
   int   quiet_cycles;

   function automatic void ring_try_start();
      if (m_armed && !m_closing && m_fill >= m_target)
         m_started = 1'b1;
   endfunction

   function automatic void ring_set_reg(input csr_index_type idx, input logic [15:0] val);
      case (idx)
         CSR_CHANNELS: m_channels = val[3:0];
         CSR_TARGET:   m_target = val;
         CSR_CAPACITY: begin
            // rewriting the capacity flushes the ring
            m_capacity = val;
            m_rd = 0;
            m_wr = 0;
            m_fill = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void ring_apply(input cmd_type cmd, input logic cb, input logic [127:0] din);
      ring_rsp_type r;
      int unsigned  cap, lanes, slot;
      cap = m_capacity;
      if (cap < 1) cap = 1;
      if (cap > RING_DEPTH_DEFAULT) cap = RING_DEPTH_DEFAULT;
      lanes = m_channels;
      if (lanes < 1) lanes = 1;
      if (lanes > MAX_CHANNELS_DEFAULT) lanes = MAX_CHANNELS_DEFAULT;
      r.frame = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_WRITE: begin
            if (m_closing) begin
               r.status = ST_REFUSED;
            end else begin
               if (m_fill >= cap) begin
                  r.status = ST_DROP_FULL;
                  m_drop = m_drop + 1;
               end else begin
                  slot = m_wr % cap;
                  ring_model[slot] = din;
                  m_wr = (slot + 1 >= cap) ? 0 : slot + 1;
                  m_fill = m_fill + 1;
               end
               ring_try_start();
            end
         end
         CMD_READ: begin
            if (m_closing) begin
               r.status = ST_STOPPED;
            end else begin
               if (cb) m_cb_short = 1'b0;
               if (m_fill == 0) begin
                  r.status = ST_UNDERRUN;
                  m_ufr = m_ufr + 1;
                  // one callback counted however many frames it misses
                  if (!m_cb_short) begin
                     m_ucb = m_ucb + 1;
                     m_cb_short = 1'b1;
                  end
               end else begin
                  slot = m_rd % cap;
                  r.frame = ring_model[slot];
                  for (int l = 0; l < LANE_COUNT; l++)
                     if (l >= lanes) r.frame[16*l +: 16] = 16'h0000;
                  m_rd = (slot + 1 >= cap) ? 0 : slot + 1;
                  m_fill = m_fill - 1;
               end
            end
         end
         CMD_ARM: begin
            m_armed = 1'b1;
            ring_try_start();
         end
         default: begin
            m_closing = 1'b1;
            m_armed = 1'b0;
            m_started = 1'b0;
         end
      endcase
      r.queued = m_fill[15:0];
      r.playing = m_started;
      r.ucb = m_ucb;
      r.ufr = m_ufr;
      r.drop = m_drop;
      ring_replies.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_cmd(input cmd_type c, input logic cb, input logic [127:0] d);
      cmd_step_type s;
      s.kind = STEP_ITEM;
      s.cmd = c;
      s.cb = cb;
      s.data = d;
      cmd_backlog.push_back(s);
   endfunction

   // registers only change with the block drained
   function automatic void queue_reg(input csr_index_type i, input logic [15:0] v);
      cmd_step_type s;
      s.kind = STEP_DRAIN;
      cmd_backlog.push_back(s);
      s.kind = STEP_REG;
      s.idx = i;
      s.wdata = v;
      cmd_backlog.push_back(s);
   endfunction

   function automatic void queue_mode(input int idle, input int stall);
      cmd_step_type s;
      s.kind = STEP_MODE;
      s.idle_pct = idle;
      s.stall_pct = stall;
      cmd_backlog.push_back(s);
   endfunction

   function automatic logic [127:0] rand_frame();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // driver
   always @(negedge clock) begin : drive_req
      cmd_step_type s;
      logic         rv, cv;
      rv = req_valid && !req_taken;
      cv = csr_valid && !csr_taken;
      if (!reset && !rv && !cv) begin
         if (settle_left > 0) begin
            settle_left = settle_left - 1;
         end else if (draining) begin
            if (ring_replies.size() == 0) begin
               draining = 1'b0;
               settle_left = SETTLE_CYCLES;
            end
         end else if (cmd_backlog.size() != 0) begin
            case (cmd_backlog[0].kind)
               STEP_ITEM: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     s = cmd_backlog.pop_front();
                     rv = 1'b1;
                     req_command <= s.cmd;
                     req_callback_start <= s.cb;
                     req_in_pair_0 <= s.data[31:0];
                     req_in_pair_1 <= s.data[63:32];
                     req_in_pair_2 <= s.data[95:64];
                     req_in_pair_3 <= s.data[127:96];
                  end
               end
               STEP_REG: begin
                  s = cmd_backlog.pop_front();
                  cv = 1'b1;
                  csr_index <= s.idx;
                  csr_wdata <= s.wdata;
               end
               STEP_DRAIN: begin
                  s = cmd_backlog.pop_front();
                  draining = 1'b1;
               end
               default: begin
                  s = cmd_backlog.pop_front();
                  send_idle_pct = s.idle_pct;
                  rsp_stall_pct = s.stall_pct;
               end
            endcase
         end
      end
      req_valid <= rv;
      csr_valid <= cv;
   end

   always @(negedge clock) begin : drive_stall
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor
   always @(posedge clock) begin : watch_ports
      ring_rsp_type want;
      logic [127:0] got_frame;
      req_taken <= !reset && req_valid && !req_stall;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (ring_replies.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = ring_replies.pop_front();
               got_frame = {rsp_out_pair_3, rsp_out_pair_2, rsp_out_pair_1, rsp_out_pair_0};
               for (int p = 0; p < PAIR_COUNT; p++)
                  check_field($sformatf("out_pair_%0d", p), want.frame[32*p +: 32],
                              got_frame[32*p +: 32]);
               check_field("status", want.status, rsp_status);
               check_field("queued_frames", want.queued, rsp_queued_frames);
               check_field("playing", want.playing, rsp_playing);
               check_field("underrun_callback_count", want.ucb, rsp_underrun_callback_count);
               check_field("underrun_frame_count", want.ufr, rsp_underrun_frame_count);
               check_field("dropped_frame_count", want.drop, rsp_dropped_frame_count);
            end
         end
         if (csr_valid && csr_ready)
            ring_set_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_valid && !req_stall)
            ring_apply(cmd_type'(req_command), req_callback_start,
                       {req_in_pair_3, req_in_pair_2, req_in_pair_1, req_in_pair_0});
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          cap_eff, left, burst, pick, seg, ch;
      logic [15:0] cap_val;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_callback_start = 1'b0;
      req_in_pair_0 = '0;
      req_in_pair_1 = '0;
      req_in_pair_2 = '0;
      req_in_pair_3 = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CHANNELS;
      csr_wdata = '0;
      mismatches = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      draining = 1'b0;
      settle_left = 0;
      req_taken = 1'b0;
      csr_taken = 1'b0;
      quiet_cycles = 0;
      m_rd = 0;
      m_wr = 0;
      m_fill = 0;
      m_armed = 1'b0;
      m_started = 1'b0;
      m_closing = 1'b0;
      m_cb_short = 1'b0;
      m_ucb = '0;
      m_ufr = '0;
      m_drop = '0;
      m_channels = CHANNELS_RESET;
      m_target = TARGET_RESET;
      m_capacity = 16'(CAPACITY_RESET);

      // underruns on an empty ring, one callback counted per marker
      queue_cmd(CMD_READ, 1'b1, '0);
      queue_cmd(CMD_READ, 1'b0, '1);
      queue_cmd(CMD_READ, 1'b1, '0);
      // writes before arm do not start playback; marker on a write is ignored
      queue_cmd(CMD_WRITE, 1'b1, '1);
      queue_cmd(CMD_WRITE, 1'b0, '0);
      queue_reg(CSR_TARGET, 16'd4);
      queue_cmd(CMD_ARM, 1'b0, rand_frame());
      queue_cmd(CMD_WRITE, 1'b0, rand_frame());
      queue_cmd(CMD_WRITE, 1'b0, rand_frame());
      // two channels: upper lanes masked on readout
      queue_cmd(CMD_READ, 1'b0, '0);
      queue_cmd(CMD_READ, 1'b0, '0);
      queue_reg(CSR_CHANNELS, 16'hFFF8);
      queue_reg(CSR_CAPACITY, 16'd2);
      queue_reg(CSR_TARGET, 16'd0);
      queue_cmd(CMD_WRITE, 1'b0, '1);
      queue_cmd(CMD_WRITE, 1'b0, {8{16'h8000}});
      queue_cmd(CMD_WRITE, 1'b0, rand_frame());
      queue_cmd(CMD_READ, 1'b0, '0);
      queue_cmd(CMD_READ, 1'b0, '0);
      queue_cmd(CMD_READ, 1'b1, '0);
      queue_cmd(CMD_ARM, 1'b1, '1);
      // zero channels and zero capacity act as one
      queue_reg(CSR_CHANNELS, 16'h0000);
      queue_reg(CSR_CAPACITY, 16'h0000);
      queue_reg(CSR_TARGET, 16'h8000);
      queue_reg(CSR_UNUSED, 16'($urandom));
      queue_cmd(CMD_WRITE, 1'b0, '1);
      queue_cmd(CMD_WRITE, 1'b0, rand_frame());
      queue_cmd(CMD_READ, 1'b0, '0);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: queue_mode(0, 0);
            1: queue_mode(65, 0);
            2: queue_mode(0, 65);
            default: queue_mode(9, 9);
         endcase
         case (seg)
            0: ch = 1;
            1: ch = 8;
            2: ch = 15;
            3: ch = 3;
            default: ch = $urandom_range(15);
         endcase
         case (seg)
            0: cap_val = 16'd1;
            1: cap_val = 16'd4;
            2: cap_val = 16'd32768;
            3: cap_val = 16'd3;
            4: cap_val = 16'hFFFF;
            5: cap_val = 16'd8;
            default: cap_val = 16'($urandom_range(2, 16));
         endcase
         cap_eff = (cap_val > RING_DEPTH_DEFAULT) ? RING_DEPTH_DEFAULT : int'(cap_val);
         queue_reg(CSR_CHANNELS, {12'($urandom), 4'(ch)});
         queue_reg(CSR_CAPACITY, cap_val);
         if (seg == 6) queue_reg(CSR_TARGET, 16'd32768);
         else queue_reg(CSR_TARGET, 16'($urandom_range(0, 8)));
         left = SEGMENT_ITEMS;
         while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               burst = $urandom_range(1, ((cap_eff > 6) ? 6 : cap_eff) + 2);
               if (burst > left) burst = left;
               for (int i = 0; i < burst; i++)
                  queue_cmd(CMD_WRITE, 1'($urandom_range(1)), rand_frame());
            end else if (pick < 90) begin
               // one consumer callback: marker on its first frame only
               burst = $urandom_range(1, 6);
               if (burst > left) burst = left;
               for (int i = 0; i < burst; i++)
                  queue_cmd(CMD_READ, (i == 0), rand_frame());
            end else begin
               burst = 1;
               queue_cmd(cmd_type'($urandom_range(2)), 1'($urandom_range(1)), rand_frame());
            end
            left = left - burst;
         end
      end

      // close is sticky, so it only comes at the very end
      queue_mode(9, 9);
      queue_cmd(CMD_WRITE, 1'b0, '1);
      queue_cmd(CMD_CLOSE, 1'b1, rand_frame());
      queue_cmd(CMD_WRITE, 1'b0, rand_frame());
      queue_cmd(CMD_READ, 1'b1, '0);
      queue_cmd(CMD_ARM, 1'b0, '0);
      queue_cmd(CMD_CLOSE, 1'b0, '0);
      for (int i = 0; i < 10; i++)
         queue_cmd(cmd_type'($urandom_range(3)), 1'($urandom_range(1)), rand_frame());

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || csr_valid || draining ||
             settle_left != 0 || ring_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ring_replies.size() != 0) begin
         $error("%0d responses never arrived", ring_replies.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
